FILE: src/cstk_pkg.sv
// ============================================================================
// cstk_pkg: shared definitions for the C source token scanner
// Widths, character codes, byte-role codes, class functions and the
// per-byte result structure.
// ============================================================================
package cstk_pkg;

    localparam int LINE_BITS = 24;
    localparam int WORD_BITS = 16;

    // Role that the current byte plays in the token stream.
    localparam logic [1:0] ROLE_SKIP  = 2'd0;
    localparam logic [1:0] ROLE_START = 2'd1;
    localparam logic [1:0] ROLE_CONT  = 2'd2;
    localparam logic [1:0] ROLE_END   = 2'd3;

    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] LEAD_MIN     = 8'h80;

    typedef struct packed {
        logic                 held_valid;
        logic                 held_role;
        logic                 token_closed;
        logic [WORD_BITS-1:0] closed_word_index;
        logic                 cur_decided;
        logic [1:0]           cur_role;
        logic [LINE_BITS-1:0] line_count;
    } t_result;

    // Characters that open an operator token from idle.
    function automatic logic op_start(input logic [7:0] b);
        logic hit;
        case (b) inside
            8'h7B, 8'h7D, 8'h3B, 8'h2C, 8'h25, 8'h21, 8'h5C,
            8'h2B, 8'h2D, 8'h2A, 8'h3D, 8'h3E, 8'h3C, 8'h26,
            8'h7E, 8'h5E, 8'h7C, 8'h3A, 8'h28, 8'h29: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Characters that extend an open operator token.
    function automatic logic op_cont(input logic [7:0] b);
        logic hit;
        case (b) inside
            8'h21, 8'h25, 8'h3E, 8'h3C, 8'h3D, 8'h2B, 8'h2D, 8'h2A,
            8'h2F, 8'h26, 8'h7C, 8'h3A, 8'h7E, 8'h5E, 8'h5C: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic word_delim(input logic [7:0] b);
        return (b == CH_DQUOTE) || (b == CH_SQUOTE) || (b == CH_NEWLINE) ||
               (b == CH_CR) || (b == CH_TAB) || (b == CH_SPACE) ||
               (b == CH_SLASH) || op_start(b);
    endfunction

endpackage

FILE: src/cstk_if.sv
// ============================================================================
// cstk channel interfaces
// Byte request channel into the scanner and result channel out of it.
// ============================================================================
interface cstk_in_if;
    import cstk_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface cstk_out_if;
    import cstk_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 held_valid;
    logic                 held_role;
    logic                 token_closed;
    logic [WORD_BITS-1:0] closed_word_index;
    logic                 cur_decided;
    logic [1:0]           cur_role;
    logic [LINE_BITS-1:0] line_count;

    modport source (
        output valid, output held_valid, output held_role, output token_closed,
        output closed_word_index, output cur_decided, output cur_role,
        output line_count, input ready
    );
    modport sink (
        input valid, input held_valid, input held_role, input token_closed,
        input closed_word_index, input cur_decided, input cur_role,
        input line_count, output ready
    );
endinterface

FILE: src/cstk_step.sv
// ============================================================================
// cstk_step: scanner state and single-byte step logic
// Holds the scan mode and counters, forms the result for the byte in the
// input register and updates the state when that byte moves on.
// ============================================================================
module cstk_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  logic              i_eoi,
    output cstk_pkg::t_result o_res
);
    import cstk_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_WORD  = 3'd1,
        M_OPER  = 3'd2,
        M_DQ    = 3'd3,
        M_SQ    = 3'd4,
        M_LINE  = 3'd5,
        M_BLOCK = 3'd6
    } t_mode;

    t_mode                r_mode,  n_mode;
    logic                 r_star,  n_star;
    logic                 r_esc,   n_esc;
    logic                 r_trail, n_trail;
    logic                 r_trail_tok, n_trail_tok;
    logic                 r_slash, n_slash;
    logic [LINE_BITS-1:0] r_lines, n_lines;
    logic [WORD_BITS-1:0] r_word,  n_word;

    always_comb begin
        t_mode m;
        logic  in_tok;
        logic  do_close;
        logic  do_idle;

        o_res             = '0;
        o_res.cur_decided = 1'b1;
        o_res.cur_role    = ROLE_SKIP;
        n_mode      = r_mode;
        n_star      = r_star;
        n_esc       = r_esc;
        n_trail     = r_trail;
        n_trail_tok = r_trail_tok;
        n_slash     = r_slash;
        n_lines     = r_lines;
        n_word      = r_word;
        do_close    = 1'b0;
        do_idle     = 1'b0;
        m           = r_slash ? M_OPER : r_mode;
        in_tok      = (m == M_WORD) || (m == M_OPER) || (m == M_DQ) || (m == M_SQ);

        if (i_eoi) begin
            o_res.held_valid = r_slash;
            if (in_tok && !r_slash) begin
                o_res.token_closed      = 1'b1;
                o_res.closed_word_index = r_word;
            end
            o_res.line_count = r_lines;
            n_mode      = M_IDLE;
            n_star      = 1'b0;
            n_esc       = 1'b0;
            n_trail     = 1'b0;
            n_trail_tok = 1'b0;
            n_slash     = 1'b0;
            n_lines     = '0;
            n_word      = '0;
        end else begin
            if (r_trail) begin
                // Trail byte of a multi-byte character copies the lead's role.
                n_trail        = 1'b0;
                n_trail_tok    = 1'b0;
                o_res.cur_role = r_trail_tok ? ROLE_CONT : ROLE_SKIP;
            end else if (r_slash && i_byte == CH_SLASH) begin
                n_slash          = 1'b0;
                o_res.held_valid = 1'b1;
                n_mode           = M_LINE;
            end else if (r_slash && i_byte == CH_STAR) begin
                n_slash          = 1'b0;
                o_res.held_valid = 1'b1;
                n_mode           = M_BLOCK;
                n_star           = 1'b0;
            end else begin
                if (r_slash) begin
                    // The held slash turns out to start an operator token.
                    n_slash          = 1'b0;
                    o_res.held_valid = 1'b1;
                    o_res.held_role  = 1'b1;
                    n_mode           = M_OPER;
                end
                if ((m == M_DQ || m == M_SQ) && r_esc) begin
                    n_esc          = 1'b0;
                    o_res.cur_role = ROLE_CONT;
                end else if (i_byte >= LEAD_MIN && m != M_IDLE && m <= M_BLOCK) begin
                    n_trail        = 1'b1;
                    n_trail_tok    = in_tok;
                    o_res.cur_role = in_tok ? ROLE_CONT : ROLE_SKIP;
                end else begin
                    case (m)
                        M_LINE: begin
                            if (i_byte == CH_NEWLINE) begin
                                n_lines = r_lines + 1'b1;
                                n_word  = '0;
                                n_mode  = M_IDLE;
                            end
                        end
                        M_BLOCK: begin
                            if (i_byte == CH_STAR) begin
                                n_star = 1'b1;
                            end else if (i_byte == CH_SLASH) begin
                                if (r_star) begin
                                    n_star = 1'b0;
                                    n_mode = M_IDLE;
                                end
                            end else begin
                                n_star = 1'b0;
                            end
                        end
                        M_DQ, M_SQ: begin
                            if (i_byte == CH_BACKSLASH) begin
                                n_esc          = 1'b1;
                                o_res.cur_role = ROLE_CONT;
                            end else if ((m == M_DQ && i_byte == CH_DQUOTE) ||
                                         (m == M_SQ && i_byte == CH_SQUOTE)) begin
                                o_res.cur_role = ROLE_END;
                                do_close       = 1'b1;
                                n_mode         = M_IDLE;
                            end else begin
                                o_res.cur_role = ROLE_CONT;
                            end
                        end
                        M_OPER: begin
                            if (op_cont(i_byte)) begin
                                o_res.cur_role = ROLE_CONT;
                            end else begin
                                do_close = 1'b1;
                                do_idle  = 1'b1;
                            end
                        end
                        M_WORD: begin
                            if (word_delim(i_byte)) begin
                                do_close = 1'b1;
                                do_idle  = 1'b1;
                            end else begin
                                o_res.cur_role = ROLE_CONT;
                            end
                        end
                        default: do_idle = 1'b1;
                    endcase
                end

                if (do_close) begin
                    o_res.token_closed      = 1'b1;
                    o_res.closed_word_index = r_word;
                    if (r_word != '1) begin
                        n_word = r_word + 1'b1;
                    end
                end

                if (do_idle) begin
                    n_mode = M_IDLE;
                    if (i_byte >= LEAD_MIN) begin
                        n_trail     = 1'b1;
                        n_trail_tok = 1'b0;
                    end else if (i_byte == CH_DQUOTE || i_byte == CH_SQUOTE) begin
                        n_mode         = (i_byte == CH_DQUOTE) ? M_DQ : M_SQ;
                        n_esc          = 1'b0;
                        o_res.cur_role = ROLE_START;
                    end else if (i_byte == CH_NEWLINE) begin
                        n_lines = r_lines + 1'b1;
                        n_word  = '0;
                    end else if (i_byte == CH_CR || i_byte == CH_TAB ||
                                 i_byte == CH_SPACE) begin
                        o_res.cur_role = ROLE_SKIP;
                    end else if (i_byte == CH_SLASH) begin
                        n_slash           = 1'b1;
                        o_res.cur_decided = 1'b0;
                    end else if (op_start(i_byte)) begin
                        n_mode         = M_OPER;
                        o_res.cur_role = ROLE_START;
                    end else begin
                        n_mode         = M_WORD;
                        o_res.cur_role = ROLE_START;
                    end
                end
            end
            o_res.line_count = n_lines;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_star      <= 1'b0;
            r_esc       <= 1'b0;
            r_trail     <= 1'b0;
            r_trail_tok <= 1'b0;
            r_slash     <= 1'b0;
            r_lines     <= '0;
            r_word      <= '0;
        end else if (i_en) begin
            r_mode      <= n_mode;
            r_star      <= n_star;
            r_esc       <= n_esc;
            r_trail     <= n_trail;
            r_trail_tok <= n_trail_tok;
            r_slash     <= n_slash;
            r_lines     <= n_lines;
            r_word      <= n_word;
        end
    end

endmodule

FILE: src/c_source_token_scanner_core.sv
// ============================================================================
// c_source_token_scanner_core: C source token boundary scanner
// Input register, single-pass step logic and a result register.
// ============================================================================
// The scanner takes one source byte per request on i_in and returns exactly
// one result per request on o_out, in order. Each result tells whether a token
// closed before or with the byte, the role of the byte, whether a held slash
// was resolved, and the running line count.
// A request with end_of_input set closes any open token, drops a held slash
// and returns all scanner state to its reset value after its result.
// A byte accepted on i_in sits in the input register; its result is loaded
// into the output register once the output is free and is shown from then
// on. Throughput is one byte per clock while the receiver does not stall,
// set by the step logic between the two registers and the state it updates.
// When the receiver stalls, the result stays in the output register and one
// more byte may wait in the input register; after that i_in.ready falls.
// i_rst_n is synchronous and active low; it empties both registers and
// clears the mode, the line count and the word index.
// ============================================================================
module c_source_token_scanner_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cstk_in_if.sink    i_in,
    cstk_out_if.source o_out
);
    import cstk_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       out_free;
    logic       step_fire;

    assign out_free  = !r_out_valid || o_out.ready;
    assign step_fire = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    cstk_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step_fire),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.held_valid        = r_out.held_valid;
    assign o_out.held_role         = r_out.held_role;
    assign o_out.token_closed      = r_out.token_closed;
    assign o_out.closed_word_index = r_out.closed_word_index;
    assign o_out.cur_decided       = r_out.cur_decided;
    assign o_out.cur_role          = r_out.cur_role;
    assign o_out.line_count        = r_out.line_count;

`ifndef NO_ASSERTIONS
    // A byte held as a possible comment opener has no role yet.
    a_undecided_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.cur_decided) |-> (r_out.cur_role == ROLE_SKIP))
        else $error("undecided byte carries a role");

    // A slash role is only reported together with its resolution.
    a_held_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.held_role) |-> r_out.held_valid)
        else $error("held slash role without resolution");

    // A waiting input byte is neither lost nor changed while the output stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step_fire) |=>
            (r_in_valid && $stable(r_in_byte) && $stable(r_in_eoi)))
        else $error("input register changed while stalled");

    // Outside end of input the line count holds or moves forward by one.
    a_line_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && !r_in_eoi) |->
            (step_res.line_count == u_step.r_lines ||
             step_res.line_count == LINE_BITS'(u_step.r_lines + 1'b1)))
        else $error("line count mismatch");
`endif

endmodule
